FILE: rtl/core/pde_pkg.sv
// Package for the Playfair digraph encryptor: letter codes, request and job
// types, back-end states and the small square-geometry helper functions.
// Depends on nothing; every other file of the block but pde_ram imports it.
package pde_pkg;

	localparam int SQUARE_SIDE  = 5;
	localparam int SQUARE_SIZE  = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTER_COUNT = 26;
	localparam int LETTER_W     = 5;
	localparam int RC_W         = 3;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [RC_W-1:0]     rc_t;

	localparam letter_t CODE_I = letter_t'(8);
	localparam letter_t CODE_J = letter_t'(9);
	localparam letter_t CODE_X = letter_t'(23);

	// Request codes carried by req_type.
	typedef enum logic [1:0] {
		REQ_KEY_LETTER  = 2'd0,
		REQ_KEY_END     = 2'd1,
		REQ_TEXT_LETTER = 2'd2,
		REQ_MSG_END     = 2'd3
	} req_type_t;

	// Work handed from the front end to the back end.
	typedef enum logic [1:0] {
		JOB_PLACE = 2'd0,
		JOB_FILL  = 2'd1,
		JOB_PAIR  = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		letter_t   first;
		letter_t   second;
		logic      last;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_POS,
		ST_SQ,
		ST_OUT_A,
		ST_OUT_B
	} back_state_t;

	// The letter j shares the square cell of i.
	function automatic letter_t fold_j(input letter_t c);
		return (c == CODE_J) ? CODE_I : c;
	endfunction

	// Row of a square position: position * 13 / 64 equals position / 5 below 25.
	function automatic rc_t pos_row(input letter_t p);
		logic [8:0] prod;
		prod = 9'(p) * 9'd13;
		return prod[8:6];
	endfunction

	// Column of a square position.
	function automatic rc_t pos_col(input letter_t p);
		rc_t     r;
		letter_t t;
		r = pos_row(p);
		t = p - (letter_t'({r, 2'b00}) + letter_t'(r));
		return t[RC_W-1:0];
	endfunction

	// Step to the next row or column with wraparound.
	function automatic rc_t rc_next(input rc_t x);
		return (x == rc_t'(SQUARE_SIDE - 1)) ? rc_t'(0) : x + rc_t'(1);
	endfunction

	// Row-major square index.
	function automatic letter_t sq_index(input rc_t r, input rc_t c);
		return letter_t'({r, 2'b00}) + letter_t'(r) + letter_t'(c);
	endfunction

endpackage

FILE: rtl/core/pde_ram.sv
// Generic RAM with one write port and two registered read ports.
// Self-contained; used for the letter square and the letter position table.
module pde_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/core/pde_front.sv
// Front end: accepts requests, holds the filler register, the key-done flag
// and the open digraph letter, and turns requests into back-end jobs.
// Depends on pde_pkg.
module pde_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      req_type,
	input  logic [4:0]      letter,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [4:0]      cfg_data,
	output logic            q_push,
	output pde_pkg::job_t   q_job,
	input  logic            q_full
);
	import pde_pkg::*;

	letter_t filler_q;
	logic    key_done_q;
	logic    held_valid_q;
	letter_t held_q;

	logic    accept;
	logic    in_range;
	letter_t text_c;
	letter_t pad;
	logic    key_done_d;
	logic    held_valid_d;
	letter_t held_d;

	// The queue is the only source of back pressure.
	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign in_range  = (letter < letter_t'(LETTER_COUNT));
	assign text_c    = fold_j(letter);
	assign pad       = fold_j((filler_q >= letter_t'(LETTER_COUNT)) ? CODE_X : filler_q);

	// Filler register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q <= CODE_X;
		end else if (cfg_valid && cfg_ready) begin
			filler_q <= cfg_data;
		end
	end

	// Classify the request and build a job.
	always_comb begin
		q_push       = 1'b0;
		q_job        = '{kind: JOB_PLACE, first: text_c, second: pad, last: 1'b0};
		key_done_d   = key_done_q;
		held_valid_d = held_valid_q;
		held_d       = held_q;
		if (accept) begin
			unique case (req_type_t'(req_type))
				REQ_KEY_LETTER: begin
					if (!key_done_q && in_range) begin
						q_push = 1'b1;
					end
				end
				REQ_KEY_END: begin
					if (!key_done_q) begin
						q_push     = 1'b1;
						q_job.kind = JOB_FILL;
						key_done_d = 1'b1;
					end
				end
				REQ_TEXT_LETTER: begin
					if (key_done_q && in_range) begin
						if (!held_valid_q) begin
							held_d       = text_c;
							held_valid_d = 1'b1;
						end else if (held_q == text_c) begin
							// Doubled letter: pad the first, keep the second open.
							q_push      = 1'b1;
							q_job.kind  = JOB_PAIR;
							q_job.first = held_q;
						end else begin
							q_push       = 1'b1;
							q_job.kind   = JOB_PAIR;
							q_job.first  = held_q;
							q_job.second = text_c;
							held_valid_d = 1'b0;
						end
					end
				end
				REQ_MSG_END: begin
					if (key_done_q && held_valid_q) begin
						q_push       = 1'b1;
						q_job.kind   = JOB_PAIR;
						q_job.first  = held_q;
						q_job.last   = 1'b1;
						held_valid_d = 1'b0;
					end
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_done_q   <= 1'b0;
			held_valid_q <= 1'b0;
		end else begin
			key_done_q   <= key_done_d;
			held_valid_q <= held_valid_d;
		end
	end

	// Open digraph letter.
	always_ff @(posedge clk) begin
		held_q <= held_d;
	end

`ifndef ASSERT_OFF
	a_held_after_key: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> key_done_q)
		else $error("open digraph letter held before the key was finished");
`endif

endmodule

FILE: rtl/core/pde_queue.sv
// Short job queue between the front end and the back end.
// Depends on pde_pkg.
module pde_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pde_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output pde_pkg::job_t head_job,
	output logic          empty
);
	import pde_pkg::*;

	job_t                slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> (count_q == QCNT_W'(QUEUE_DEPTH)) && !$past(push))
		else $error("job queue written while full");
`endif

endmodule

FILE: rtl/core/pde_back.sv
// Back end: builds the letter square from place and fill jobs and encrypts
// digraph jobs through the position table and the square.
// Depends on pde_pkg and pde_ram.
module pde_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  pde_pkg::job_t q_job,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [4:0]    cipher_letter,
	output logic          last_of_message
);
	import pde_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [LETTER_COUNT-1:0] used_q;
	letter_t     fill_q;
	letter_t     k_q;
	letter_t     k_d;
	logic        last_q;
	letter_t     ea_q;
	letter_t     eb_q;

	letter_t     cand;
	logic        place_en;
	logic        do_write;
	letter_t     pos_a;
	letter_t     pos_b;
	letter_t     sq_a;
	letter_t     sq_b;
	letter_t     idx_a;
	letter_t     idx_b;
	rc_t         ra;
	rc_t         ca;
	rc_t         rb;
	rc_t         cb;

	// Square: index to letter. Position table: letter to index.
	pde_ram #(.WIDTH(LETTER_W), .DEPTH(SQUARE_SIZE)) u_square (
		.clk     (clk),
		.we      (do_write),
		.waddr   (fill_q),
		.wdata   (cand),
		.raddr_a (idx_a),
		.raddr_b (idx_b),
		.rdata_a (sq_a),
		.rdata_b (sq_b)
	);

	pde_ram #(.WIDTH(LETTER_W), .DEPTH(LETTER_COUNT)) u_position (
		.clk     (clk),
		.we      (do_write),
		.waddr   (cand),
		.wdata   (fill_q),
		.raddr_a (q_job.first),
		.raddr_b (q_job.second),
		.rdata_a (pos_a),
		.rdata_b (pos_b)
	);

	// Square geometry of the looked-up pair.
	always_comb begin
		ra = pos_row(pos_a);
		ca = pos_col(pos_a);
		rb = pos_row(pos_b);
		cb = pos_col(pos_b);
		if (ra == rb) begin
			idx_a = sq_index(ra, rc_next(ca));
			idx_b = sq_index(rb, rc_next(cb));
		end else if (ca == cb) begin
			idx_a = sq_index(rc_next(ra), ca);
			idx_b = sq_index(rc_next(rb), cb);
		end else begin
			idx_a = sq_index(ra, cb);
			idx_b = sq_index(rb, ca);
		end
	end

	// Next state, job pop and square writes.
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		q_pop     = 1'b0;
		place_en  = 1'b0;
		cand      = q_job.first;
		out_valid = 1'b0;
		cipher_letter   = ea_q;
		last_of_message = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_job.kind)
						JOB_PLACE: place_en = 1'b1;
						JOB_FILL: begin
							k_d     = '0;
							state_d = ST_FILL;
						end
						JOB_PAIR: state_d = ST_POS;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				cand     = k_q;
				place_en = (k_q != CODE_J);
				k_d      = k_q + letter_t'(1);
				if (k_q == letter_t'(LETTER_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_POS: state_d = ST_SQ;
			ST_SQ:  state_d = ST_OUT_A;
			ST_OUT_A: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_OUT_B;
				end
			end
			ST_OUT_B: begin
				out_valid       = 1'b1;
				cipher_letter   = eb_q;
				last_of_message = last_q;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		do_write = place_en && !used_q[cand] && (fill_q < letter_t'(SQUARE_SIZE));
	end

	// Control state: sequencer, letter-in-square flags, fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			fill_q  <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (do_write) begin
				used_q[cand] <= 1'b1;
				fill_q       <= fill_q + letter_t'(1);
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			last_q <= q_job.last;
		end
		if (state_q == ST_SQ) begin
			ea_q <= sq_a;
			eb_q <= sq_b;
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= letter_t'(SQUARE_SIZE))
		else $error("square fill count beyond the square size");
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(fill_q))
		else $error("letter flags disagree with the fill count");
	a_fill_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && state_d == ST_IDLE) |=> (fill_q == letter_t'(SQUARE_SIZE)))
		else $error("square incomplete after key end");
`endif

endmodule

FILE: rtl/core/playfair_digraph_encryptor.sv
// Top level of the Playfair digraph encryptor: front end, job queue, back end.
// Depends on pde_pkg, pde_front, pde_queue and pde_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     req_type, letter
//   out      output     out_valid / out_stall   cipher_letter, last_of_message
//   cfg      input      cfg_valid / cfg_ready   cfg_data (filler letter)
//
// The front end takes one request a cycle while the four-entry job queue has room.
// In the back end a key letter is placed when it is popped, a key end pops and then
// offers each letter of the alphabet in turn, and a digraph passes the pop, the two
// registered memory reads (position table, then square) and one state for each
// result, plus any output stall.
// arst_n clears the key, the open digraph letter and the queue; filler resets to x.
// in_stall follows the queue being full; out_stall holds the current result.
module playfair_digraph_encryptor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [4:0] letter,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] cipher_letter,
	output logic       last_of_message,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);
	import pde_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t head_job;

	pde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.letter    (letter),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_job     (push_job),
		.q_full    (q_full)
	);

	pde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	pde_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_job           (head_job),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cipher_letter   (cipher_letter),
		.last_of_message (last_of_message)
	);

endmodule

FILE: verif/pde_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Playfair digraph encryptor. It watches the request,
// result and filler channels, keeps its own copy of the square and predicts
// every cipher letter. Depends on pde_pkg for the letter and request types.
module pde_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [4:0] letter,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [4:0] cipher_letter,
	input  logic       last_of_message,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [4:0] cfg_data,
	output int         mismatch_count,
	output int         results_pending
);
	import pde_pkg::*;

	typedef struct {
		letter_t ch;
		logic    last;
	} cipher_out_t;

	localparam int REPORT_LIMIT = 10;

	// Expected cipher letters in order, and the predicted block state.
	cipher_out_t expected_cipher [$];
	letter_t     square [SQUARE_SIZE];
	letter_t     square_pos [LETTER_COUNT];
	logic        in_square [LETTER_COUNT];
	int          square_fill;
	logic        key_closed;
	letter_t     open_letter;
	logic        open_valid;
	letter_t     filler;

	initial mismatch_count = 0;

	// The letter j lives in the cell of i.
	function automatic letter_t as_square_letter(input letter_t c);
		return (c == CODE_J) ? CODE_I : c;
	endfunction

	// Padding letter: out-of-range filler codes fall back to x.
	function automatic letter_t padding(input letter_t f);
		return as_square_letter((f >= LETTER_COUNT) ? CODE_X : f);
	endfunction

	// Append a letter to the square unless it is already there or the square is full.
	function void add_to_square(input letter_t c);
		if (in_square[c] || square_fill >= SQUARE_SIZE)
			return;
		square[square_fill] = c;
		square_pos[c] = letter_t'(square_fill);
		in_square[c] = 1'b1;
		square_fill++;
	endfunction

	// Encipher one digraph and queue its two letters.
	function void encipher_pair(input letter_t a, input letter_t b, input logic last);
		int          ra, ca, rb, cb;
		cipher_out_t first_out, second_out;
		ra = int'(square_pos[a]) / SQUARE_SIDE;
		ca = int'(square_pos[a]) % SQUARE_SIDE;
		rb = int'(square_pos[b]) / SQUARE_SIDE;
		cb = int'(square_pos[b]) % SQUARE_SIDE;
		if (ra == rb) begin
			first_out.ch  = square[ra * SQUARE_SIDE + (ca + 1) % SQUARE_SIDE];
			second_out.ch = square[rb * SQUARE_SIDE + (cb + 1) % SQUARE_SIDE];
		end else if (ca == cb) begin
			first_out.ch  = square[((ra + 1) % SQUARE_SIDE) * SQUARE_SIDE + ca];
			second_out.ch = square[((rb + 1) % SQUARE_SIDE) * SQUARE_SIDE + cb];
		end else begin
			first_out.ch  = square[ra * SQUARE_SIDE + cb];
			second_out.ch = square[rb * SQUARE_SIDE + ca];
		end
		first_out.last  = 1'b0;
		second_out.last = last;
		expected_cipher = {expected_cipher, first_out, second_out};
	endfunction

	// Update the predicted state for one accepted request.
	function void predict_request(input req_type_t kind, input letter_t code);
		letter_t c;
		c = as_square_letter(code);
		case (kind)
			REQ_KEY_LETTER: begin
				if (!key_closed && code < LETTER_COUNT)
					add_to_square(c);
			end
			REQ_KEY_END: begin
				if (!key_closed) begin
					for (int k = 0; k < LETTER_COUNT; k++)
						if (letter_t'(k) != CODE_J)
							add_to_square(letter_t'(k));
					key_closed = 1'b1;
				end
			end
			REQ_TEXT_LETTER: begin
				if (key_closed && code < LETTER_COUNT) begin
					if (!open_valid) begin
						open_letter = c;
						open_valid  = 1'b1;
					end else if (open_letter == c) begin
						// A doubled letter is split by the filler and stays open.
						encipher_pair(open_letter, padding(filler), 1'b0);
					end else begin
						encipher_pair(open_letter, c, 1'b0);
						open_valid = 1'b0;
					end
				end
			end
			default: begin
				if (key_closed && open_valid) begin
					encipher_pair(open_letter, padding(filler), 1'b1);
					open_valid = 1'b0;
				end
			end
		endcase
	endfunction

	// Compare one accepted result with the oldest expectation.
	function void check_result();
		cipher_out_t want;
		if (expected_cipher.size() == 0) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("%0t: unexpected result letter=%0d last=%0b",
					$realtime, cipher_letter, last_of_message);
			mismatch_count++;
			return;
		end
		want = expected_cipher.pop_front();
		if (cipher_letter !== want.ch || last_of_message !== want.last) begin
			if (mismatch_count < REPORT_LIMIT)
				$display("%0t: result mismatch: expected letter=%0d last=%0b, %s",
					$realtime, want.ch, want.last,
					$sformatf("got letter=%0d last=%0b", cipher_letter, last_of_message));
			mismatch_count++;
		end
	endfunction

	// Results leaving at an edge were caused by earlier requests, so check first.
	// The prediction is cleared at every edge while reset is held.
	always @(posedge clk) begin
		if (!arst_n) begin
			expected_cipher.delete();
			for (int k = 0; k < LETTER_COUNT; k++)
				in_square[k] = 1'b0;
			square_fill = 0;
			key_closed  = 1'b0;
			open_letter = '0;
			open_valid  = 1'b0;
			filler      = CODE_X;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_valid && cfg_ready)
				filler = cfg_data;
			if (in_valid && !in_stall)
				predict_request(req_type_t'(req_type), letter_t'(letter));
		end
		results_pending = expected_cipher.size();
	end

endmodule

FILE: verif/tb_playfair_digraph_encryptor.sv
`timescale 1ns / 1ps
// Top of the Playfair encryptor testbench: clock, reset, key and text request
// stimulus, filler writes, result stalls and the verdict.
// Depends on pde_pkg, the encryptor itself and the pde_checker scoreboard.
module tb_playfair_digraph_encryptor;
	import pde_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_COUNT    = 6;
	localparam int PHASE_ITEMS    = 190;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	req_type_t  req_type = REQ_KEY_LETTER;
	letter_t    letter = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] cipher_letter;
	logic       last_of_message;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	letter_t    cfg_data = '0;

	int mismatch_count;
	int results_pending;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_burst = 0;
	int quiet_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	playfair_digraph_encryptor DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.letter          (letter),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cipher_letter   (cipher_letter),
		.last_of_message (last_of_message),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	pde_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.letter          (letter),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cipher_letter   (cipher_letter),
		.last_of_message (last_of_message),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Result stalls come in bursts of random length.
	always @(posedge clk) begin
		if (stall_burst > 0) begin
			stall_burst <= stall_burst - 1;
			out_stall   <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_burst <= $urandom_range(0, 2);
			out_stall   <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: too long without any handshake means the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_playfair_digraph_encryptor NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request, after an optional idle burst, and hold it until taken.
	task automatic send_request(input req_type_t kind, input letter_t code);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		letter   <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending until every predicted result has come out.
	task automatic drain(input bit settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The filler register is only written once the block has gone idle.
	task automatic write_filler(input letter_t value);
		drain(1'b1);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		letter_t key_order [$];
		letter_t filler_plan [PHASE_COUNT];
		letter_t last_text;
		letter_t pad_code;
		letter_t swap;
		int      pick;
		int      sent;
		int      k;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with j as the filler so that it must be read as i.
		gap_pct   = 30;
		stall_pct = 30;
		write_filler(CODE_J);

		// Text and message end before the key is finished are ignored.
		send_request(REQ_TEXT_LETTER, letter_t'(2));
		send_request(REQ_MSG_END, letter_t'($urandom));

		// Key letters: j merged into i, a repeat, and codes beyond z.
		send_request(REQ_KEY_LETTER, CODE_J);
		send_request(REQ_KEY_LETTER, CODE_I);
		send_request(REQ_KEY_LETTER, letter_t'(27));
		send_request(REQ_KEY_LETTER, letter_t'(31));

		// Either a complete key, with extra letters dropped, or a partial one
		// that the key end has to fill in.
		if ($urandom_range(0, 2) == 0) begin
			for (k = 0; k < LETTER_COUNT; k++)
				if (letter_t'(k) != CODE_J && letter_t'(k) != CODE_I)
					key_order = {key_order, letter_t'(k)};
			for (k = key_order.size() - 1; k > 0; k--) begin
				pick = $urandom_range(0, k);
				swap = key_order[k];
				key_order[k] = key_order[pick];
				key_order[pick] = swap;
			end
			foreach (key_order[i])
				send_request(REQ_KEY_LETTER, key_order[i]);
			repeat (3)
				send_request(REQ_KEY_LETTER, letter_t'($urandom_range(0, 25)));
		end else begin
			repeat ($urandom_range(3, 20))
				send_request(REQ_KEY_LETTER, letter_t'($urandom_range(0, 25)));
		end
		send_request(REQ_KEY_END, letter_t'($urandom));

		// Extremes of the alphabet as one digraph.
		send_request(REQ_TEXT_LETTER, letter_t'(0));
		send_request(REQ_TEXT_LETTER, letter_t'(25));
		// A doubled letter, then a message end padding the held one.
		send_request(REQ_TEXT_LETTER, letter_t'(2));
		send_request(REQ_TEXT_LETTER, letter_t'(2));
		send_request(REQ_MSG_END, letter_t'($urandom));
		// A message end with nothing held.
		send_request(REQ_MSG_END, letter_t'($urandom));
		// j read as i doubles with i; the filler then equals the padded letter.
		send_request(REQ_TEXT_LETTER, letter_t'(31));
		send_request(REQ_TEXT_LETTER, CODE_J);
		send_request(REQ_TEXT_LETTER, CODE_I);
		send_request(REQ_MSG_END, letter_t'($urandom));
		// Key requests after the key is finished are ignored.
		send_request(REQ_KEY_LETTER, letter_t'(4));
		send_request(REQ_KEY_END, letter_t'($urandom));
		send_request(REQ_TEXT_LETTER, CODE_J);
		send_request(REQ_TEXT_LETTER, CODE_J);
		send_request(REQ_MSG_END, letter_t'($urandom));

		// Random text, one filler setting per phase; the last phase runs flat out.
		filler_plan = '{letter_t'(31), letter_t'(0), letter_t'(25), letter_t'(26),
			letter_t'($urandom_range(0, 31)), CODE_X};
		last_text = '0;
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			write_filler(filler_plan[phase]);
			if (phase == PHASE_COUNT - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(0, 2) * 20;
				stall_pct = $urandom_range(0, 2) * 20;
			end
			pad_code = (filler_plan[phase] >= LETTER_COUNT) ? CODE_X : filler_plan[phase];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					// Requests the block must ignore.
					case ($urandom_range(0, 2))
						0:       send_request(REQ_KEY_LETTER, letter_t'($urandom));
						1:       send_request(REQ_KEY_END, letter_t'($urandom));
						default: send_request(REQ_TEXT_LETTER,
							letter_t'($urandom_range(26, 31)));
					endcase
				end else begin
					if (pick < 13) begin
						send_request(REQ_MSG_END, letter_t'($urandom));
					end else if (pick < 23) begin
						send_request(REQ_TEXT_LETTER, last_text);
					end else if (pick < 27) begin
						last_text = pad_code;
						send_request(REQ_TEXT_LETTER, last_text);
					end else begin
						last_text = letter_t'($urandom_range(0, 25));
						send_request(REQ_TEXT_LETTER, last_text);
					end
					sent++;
					if ($urandom_range(0, 199) == 0)
						drain(1'b0);
				end
			end
		end

		drain(1'b1);
		if (mismatch_count == 0 && results_pending == 0)
			$display("tb_playfair_digraph_encryptor OK");
		else
			$display("tb_playfair_digraph_encryptor NOT OK");
		$finish;
	end

endmodule
